### rtl/prmf_pkg.sv
// Package for the push-relabel maximum flow unit.
// Holds shared constants and the controller/datapath command and status structs.
// Depends on nothing.
package prmf_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int CAP_WIDTH_DEF    = 16;

    localparam int VC_W      = 7;
    localparam int IDX_W     = 6;
    localparam int CAPF_W    = 16;
    localparam int IN_DATA_W = 40;
    localparam int OUT_W     = 22;
    localparam int OUT_DATA_W = 24;

    localparam logic [VC_W-1:0]  VC_RESET     = 7'd64;
    localparam logic [31:0]      INT_MAX      = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] FLOW_OUT_MAX = 22'h3F_FFFF;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_RUN   = 1'b1;
    localparam logic ST_VALID   = 1'b0;
    localparam logic ST_INVALID = 1'b1;

    typedef struct packed {
        logic cap_clr;
        logic load;
        logic run_clr;
        logic src_init;
        logic probe;
        logic probe_ptr;
        logic v_inc;
        logic sat_eval;
        logic push_eval;
        logic rev_wr;
        logic sat_end;
        logic q_take;
        logic u_load;
        logic drain_end;
        logic ptr_inc;
        logic lift_start;
        logic lift_eval;
        logic lift_end;
        logic sum_start;
        logic sum_rd;
        logic sum_acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_run;
        logic run_ok;
        logic clr_last;
        logic v_ge_n;
        logic v_is_s;
        logic push_sat;
        logic push_drn;
        logic cnt_zero;
        logic u_is_st;
        logic exu_zero;
        logic ptr_ge_n;
        logic ptr_is_u;
        logic out_free;
    } t_stat;

endpackage

### rtl/prmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for every store of the push-relabel unit; depends on nothing.
module prmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/prmf_ctrl.sv
// Controller state machine of the push-relabel unit.
// Sequences clearing, saturation, FIFO discharge, relabel and the sink sum; uses prmf_pkg.
module prmf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  prmf_pkg::t_stat i_stat,
    output prmf_pkg::t_cmd  o_cmd
);
    import prmf_pkg::*;

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_RCLR   = 5'd2;
    localparam logic [4:0] S_SINIT  = 5'd3;
    localparam logic [4:0] S_SATCHK = 5'd4;
    localparam logic [4:0] S_SATEV  = 5'd5;
    localparam logic [4:0] S_SATREV = 5'd6;
    localparam logic [4:0] S_SATEND = 5'd7;
    localparam logic [4:0] S_QCHK   = 5'd8;
    localparam logic [4:0] S_QTAKE  = 5'd9;
    localparam logic [4:0] S_UCHK   = 5'd10;
    localparam logic [4:0] S_DCHK   = 5'd11;
    localparam logic [4:0] S_DEV    = 5'd12;
    localparam logic [4:0] S_DREV   = 5'd13;
    localparam logic [4:0] S_LCHK   = 5'd14;
    localparam logic [4:0] S_LEV    = 5'd15;
    localparam logic [4:0] S_SUM0   = 5'd16;
    localparam logic [4:0] S_SUM1   = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       w_accept;
    t_cmd       w_cmd;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                w_cmd.cap_clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.load = 1'b1;
                    if (i_stat.is_run && i_stat.run_ok) n_state = S_RCLR;
                end
            end
            S_RCLR: begin
                w_cmd.run_clr = 1'b1;
                if (i_stat.clr_last) n_state = S_SINIT;
            end
            S_SINIT: begin
                w_cmd.src_init = 1'b1;
                n_state = S_SATCHK;
            end
            S_SATCHK: begin
                if (i_stat.v_ge_n) begin
                    n_state = S_SATEND;
                end else if (i_stat.v_is_s) begin
                    w_cmd.v_inc = 1'b1;
                end else begin
                    w_cmd.probe = 1'b1;
                    n_state = S_SATEV;
                end
            end
            S_SATEV: begin
                w_cmd.sat_eval = 1'b1;
                n_state = i_stat.push_sat ? S_SATREV : S_SATCHK;
            end
            S_SATREV: begin
                w_cmd.rev_wr = 1'b1;
                n_state = S_SATCHK;
            end
            S_SATEND: begin
                w_cmd.sat_end = 1'b1;
                n_state = S_QCHK;
            end
            S_QCHK: begin
                if (i_stat.cnt_zero) begin
                    w_cmd.sum_start = 1'b1;
                    n_state = S_SUM0;
                end else begin
                    n_state = S_QTAKE;
                end
            end
            S_QTAKE: begin
                w_cmd.q_take = 1'b1;
                n_state = S_UCHK;
            end
            S_UCHK: begin
                w_cmd.u_load = 1'b1;
                n_state = i_stat.u_is_st ? S_QCHK : S_DCHK;
            end
            S_DCHK: begin
                if (i_stat.exu_zero) begin
                    w_cmd.drain_end = 1'b1;
                    n_state = S_QCHK;
                end else if (i_stat.ptr_ge_n) begin
                    w_cmd.lift_start = 1'b1;
                    n_state = S_LCHK;
                end else if (i_stat.ptr_is_u) begin
                    w_cmd.ptr_inc = 1'b1;
                end else begin
                    w_cmd.probe     = 1'b1;
                    w_cmd.probe_ptr = 1'b1;
                    n_state = S_DEV;
                end
            end
            S_DEV: begin
                w_cmd.push_eval = 1'b1;
                n_state = i_stat.push_drn ? S_DREV : S_DCHK;
            end
            S_DREV: begin
                w_cmd.rev_wr = 1'b1;
                n_state = S_DCHK;
            end
            S_LCHK: begin
                if (i_stat.v_ge_n) begin
                    w_cmd.lift_end = 1'b1;
                    n_state = S_DCHK;
                end else begin
                    w_cmd.probe = 1'b1;
                    n_state = S_LEV;
                end
            end
            S_LEV: begin
                w_cmd.lift_eval = 1'b1;
                n_state = S_LCHK;
            end
            S_SUM0: begin
                if (i_stat.v_ge_n) begin
                    n_state = S_DONE;
                end else begin
                    w_cmd.sum_rd = 1'b1;
                    n_state = S_SUM1;
                end
            end
            S_SUM1: begin
                w_cmd.sum_acc = 1'b1;
                n_state = S_SUM0;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;

    a_valid_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_stat.is_run && i_stat.run_ok) |=> (r_state == S_RCLR))
        else $error("valid run did not start the clearing pass");
    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded into an occupied output register");
    a_done_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ($past(r_state) == S_SUM0 || $past(r_state) == S_DONE))
        else $error("result stage entered without the sink sum");

endmodule

### rtl/prmf_dp.sv
// Datapath of the push-relabel unit: capacity, flow, excess, height, pointer and queue stores.
// Executes the controller's commands and reports status; uses prmf_pkg and prmf_ram.
module prmf_dp #(
    parameter int MAX_VERTICES = prmf_pkg::MAX_VERTICES_DEF,
    parameter int CAP_WIDTH    = prmf_pkg::CAP_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [prmf_pkg::VC_W-1:0]       i_cfg_wdata,
    input  logic [prmf_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic                            i_in_user,
    input  prmf_pkg::t_cmd                  i_cmd,
    output prmf_pkg::t_stat                 o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [prmf_pkg::OUT_W-1:0]      o_out_flow,
    output logic                            o_out_stat
);
    import prmf_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int AW = 2 * VW;
    localparam int D2 = 1 << AW;
    localparam int FW = CAP_WIDTH + 1;
    localparam int HW = $clog2(2 * MAX_VERTICES) + 1;
    localparam int MW = (FW + 1 > 32) ? FW + 1 : 32;
    localparam int SW = FW + VW + 1;

    logic [IDX_W-1:0]  w_from, w_to, w_src, w_snk;
    logic [CAPF_W-1:0] w_capf;
    logic [NW-1:0]     w_n_eff;
    logic              w_run_ok, w_wr_ok;

    logic [VC_W-1:0]   r_vc;
    logic [AW-1:0]     r_clr;
    logic [VW-1:0]     r_s, r_t, r_u, r_pidx, r_head;
    logic [NW-1:0]     r_n, r_v, r_ptr, r_cnt;
    logic [31:0]       r_exu;
    logic [HW-1:0]     r_hu, r_low;
    logic              r_found;
    logic [FW-1:0]     r_nf;
    logic [SW-1:0]     r_sum;
    logic              r_ovalid, r_ostat;
    logic [OUT_W-1:0]  r_oflow;

    logic [CAP_WIDTH-1:0] cap_rd;
    logic [FW-1:0]        flow_rd;
    logic [31:0]          exc_rd;
    logic [HW-1:0]        hgt_rd;
    logic [NW-1:0]        nptr_rd;
    logic [VW-1:0]        que_rd;

    logic                 cap_we, flow_we, exc_we, hgt_we, nptr_we, que_we;
    logic [AW-1:0]        cap_wa, flow_wa, flow_ra;
    logic [CAP_WIDTH-1:0] cap_wd;
    logic [FW-1:0]        flow_wd;
    logic [VW-1:0]        exc_wa, hgt_wa, nptr_wa, exc_ra;
    logic [31:0]          exc_wd;
    logic [HW-1:0]        hgt_wd;
    logic [NW-1:0]        nptr_wd;

    logic [VW-1:0]  w_pidx, w_tail, w_head_nx;
    logic [MW:0]    w_cap_ext, w_f_ext, w_res, w_exu_ext, w_d, w_nf;
    logic           w_res_pos, w_push_sat, w_push_drn, w_do_push, w_enq, w_clr_low;
    logic [31:0]    w_exv_new;
    logic [NW:0]    w_tsum;
    logic [SW-1:0]  w_sum_add;
    logic           w_sum_big;
    logic [OUT_W-1:0] w_clamp;
    logic           w_bad_run, w_out_free;

    assign w_from = i_in_data[5:0];
    assign w_to   = i_in_data[11:6];
    assign w_capf = i_in_data[27:12];
    assign w_src  = i_in_data[33:28];
    assign w_snk  = i_in_data[39:34];

    assign w_n_eff  = (32'(r_vc) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(r_vc);
    assign w_run_ok = (w_src != w_snk) && (32'(w_src) < 32'(w_n_eff))
                   && (32'(w_snk) < 32'(w_n_eff));
    assign w_wr_ok  = (32'(w_from) < 32'(MAX_VERTICES)) && (32'(w_to) < 32'(MAX_VERTICES));

    assign w_pidx    = i_cmd.probe_ptr ? r_ptr[VW-1:0] : r_v[VW-1:0];
    assign w_cap_ext = (MW + 1)'(cap_rd);
    assign w_f_ext   = {{(MW + 1 - FW){flow_rd[FW-1]}}, flow_rd};
    assign w_res     = w_cap_ext - w_f_ext;
    assign w_res_pos = !w_res[MW] && (w_res != '0);
    assign w_exu_ext = (MW + 1)'(r_exu);
    assign w_d       = (w_exu_ext < w_res) ? w_exu_ext : w_res;
    assign w_nf      = w_f_ext + w_d;
    assign w_push_sat = w_res_pos && (r_exu != '0);
    assign w_push_drn = w_push_sat && (r_hu > hgt_rd);
    assign w_do_push  = (i_cmd.sat_eval && w_push_sat) || (i_cmd.push_eval && w_push_drn);
    assign w_exv_new  = exc_rd + w_d[31:0];

    assign w_tsum    = (NW + 1)'(r_head) + (NW + 1)'(r_cnt);
    assign w_tail    = (w_tsum >= (NW + 1)'(MAX_VERTICES))
                     ? VW'(w_tsum - (NW + 1)'(MAX_VERTICES)) : VW'(w_tsum);
    assign w_head_nx = (r_head == VW'(MAX_VERTICES - 1)) ? '0 : r_head + VW'(1);
    assign w_enq     = w_do_push && (exc_rd == '0) && (r_cnt != NW'(MAX_VERTICES));
    assign w_clr_low = 32'(r_clr) < 32'(MAX_VERTICES);

    assign w_sum_add = r_sum + {{(SW - FW){flow_rd[FW-1]}}, flow_rd};
    assign w_sum_big = (SW + 23)'(r_sum) > (SW + 23)'(FLOW_OUT_MAX);
    assign w_clamp   = r_sum[SW-1] ? '0 : (w_sum_big ? FLOW_OUT_MAX : OUT_W'(r_sum));

    assign w_bad_run  = i_cmd.load && (i_in_user == ACT_RUN) && !w_run_ok;
    assign w_out_free = !r_ovalid || i_out_ready;

    always_comb begin
        cap_we = i_cmd.cap_clr || (i_cmd.load && (i_in_user == ACT_WRITE) && w_wr_ok);
        cap_wa = i_cmd.cap_clr ? r_clr : {VW'(w_from), VW'(w_to)};
        cap_wd = i_cmd.cap_clr ? '0 : CAP_WIDTH'(w_capf);

        flow_we = i_cmd.run_clr || w_do_push || i_cmd.rev_wr;
        if (i_cmd.run_clr) begin
            flow_wa = r_clr;
            flow_wd = '0;
        end else if (i_cmd.rev_wr) begin
            flow_wa = {r_pidx, r_u};
            flow_wd = FW'(0) - r_nf;
        end else begin
            flow_wa = {r_u, r_pidx};
            flow_wd = w_nf[FW-1:0];
        end
        flow_ra = i_cmd.sum_rd ? {r_v[VW-1:0], r_t} : {r_u, w_pidx};

        exc_we = (i_cmd.run_clr && w_clr_low) || i_cmd.src_init || i_cmd.sat_end
              || i_cmd.drain_end || w_do_push;
        if (i_cmd.run_clr) begin
            exc_wa = r_clr[VW-1:0];
            exc_wd = '0;
        end else if (i_cmd.src_init) begin
            exc_wa = r_s;
            exc_wd = INT_MAX;
        end else if (i_cmd.sat_end || i_cmd.drain_end) begin
            exc_wa = r_u;
            exc_wd = r_exu;
        end else begin
            exc_wa = r_pidx;
            exc_wd = w_exv_new;
        end
        exc_ra = i_cmd.q_take ? que_rd : w_pidx;

        hgt_we = (i_cmd.run_clr && w_clr_low) || i_cmd.src_init || i_cmd.drain_end;
        if (i_cmd.run_clr) begin
            hgt_wa = r_clr[VW-1:0];
            hgt_wd = '0;
        end else if (i_cmd.src_init) begin
            hgt_wa = r_s;
            hgt_wd = HW'(r_n);
        end else begin
            hgt_wa = r_u;
            hgt_wd = r_hu;
        end

        nptr_we = (i_cmd.run_clr && w_clr_low) || i_cmd.drain_end;
        nptr_wa = i_cmd.run_clr ? r_clr[VW-1:0] : r_u;
        nptr_wd = i_cmd.run_clr ? '0 : r_ptr;

        que_we = w_enq;
    end

    prmf_ram #(.WIDTH(CAP_WIDTH), .DEPTH(D2)) u_cap (
        .i_clk(i_clk), .i_we(cap_we), .i_waddr(cap_wa), .i_wdata(cap_wd),
        .i_raddr({r_u, w_pidx}), .o_rdata(cap_rd)
    );
    prmf_ram #(.WIDTH(FW), .DEPTH(D2)) u_flow (
        .i_clk(i_clk), .i_we(flow_we), .i_waddr(flow_wa), .i_wdata(flow_wd),
        .i_raddr(flow_ra), .o_rdata(flow_rd)
    );
    prmf_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_exc (
        .i_clk(i_clk), .i_we(exc_we), .i_waddr(exc_wa), .i_wdata(exc_wd),
        .i_raddr(exc_ra), .o_rdata(exc_rd)
    );
    prmf_ram #(.WIDTH(HW), .DEPTH(MAX_VERTICES)) u_hgt (
        .i_clk(i_clk), .i_we(hgt_we), .i_waddr(hgt_wa), .i_wdata(hgt_wd),
        .i_raddr(exc_ra), .o_rdata(hgt_rd)
    );
    prmf_ram #(.WIDTH(NW), .DEPTH(MAX_VERTICES)) u_nptr (
        .i_clk(i_clk), .i_we(nptr_we), .i_waddr(nptr_wa), .i_wdata(nptr_wd),
        .i_raddr(que_rd), .o_rdata(nptr_rd)
    );
    prmf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_que (
        .i_clk(i_clk), .i_we(que_we), .i_waddr(w_tail), .i_wdata(r_pidx),
        .i_raddr(r_head), .o_rdata(que_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc     <= VC_RESET;
            r_clr    <= '0;
            r_head   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_vc <= i_cfg_wdata;
            if (i_cmd.cap_clr || i_cmd.run_clr) r_clr <= r_clr + AW'(1);
            if (i_cmd.src_init) begin
                r_head <= '0;
                r_cnt  <= '0;
            end else if (i_cmd.q_take) begin
                r_head <= w_head_nx;
                r_cnt  <= r_cnt - NW'(1);
            end else if (w_enq) begin
                r_cnt  <= r_cnt + NW'(1);
            end
            if (i_cmd.out_load || w_bad_run) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_in_user == ACT_RUN) && w_run_ok) begin
            r_s <= VW'(w_src);
            r_t <= VW'(w_snk);
            r_n <= w_n_eff;
        end
        if (i_cmd.probe) r_pidx <= w_pidx;

        if (i_cmd.src_init) begin
            r_u <= r_s;
        end else if (i_cmd.q_take) begin
            r_u <= que_rd;
        end

        if (i_cmd.src_init) begin
            r_exu <= INT_MAX;
        end else if (i_cmd.u_load) begin
            r_exu <= exc_rd;
        end else if (w_do_push) begin
            r_exu <= r_exu - w_d[31:0];
        end
        if (w_do_push) r_nf <= w_nf[FW-1:0];

        if (i_cmd.src_init || i_cmd.lift_start || i_cmd.sum_start) begin
            r_v <= '0;
        end else if (i_cmd.v_inc || i_cmd.sat_eval || i_cmd.lift_eval || i_cmd.sum_acc) begin
            r_v <= r_v + NW'(1);
        end

        if (i_cmd.u_load) begin
            r_ptr <= nptr_rd;
        end else if (i_cmd.lift_end) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_inc || (i_cmd.push_eval && !w_push_drn)) begin
            r_ptr <= r_ptr + NW'(1);
        end

        if (i_cmd.u_load) begin
            r_hu <= hgt_rd;
        end else if (i_cmd.lift_end && r_found) begin
            r_hu <= r_low + HW'(1);
        end

        if (i_cmd.lift_start) begin
            r_found <= 1'b0;
        end else if (i_cmd.lift_eval && (r_pidx != r_u) && w_res_pos) begin
            r_found <= 1'b1;
            if (!r_found || (hgt_rd < r_low)) r_low <= hgt_rd;
        end

        if (i_cmd.sum_start) begin
            r_sum <= '0;
        end else if (i_cmd.sum_acc) begin
            r_sum <= w_sum_add;
        end

        if (i_cmd.out_load) begin
            r_oflow <= w_clamp;
            r_ostat <= ST_VALID;
        end else if (w_bad_run) begin
            r_oflow <= '0;
            r_ostat <= ST_INVALID;
        end
    end

    assign o_stat.is_run   = (i_in_user == ACT_RUN);
    assign o_stat.run_ok   = w_run_ok;
    assign o_stat.clr_last = &r_clr;
    assign o_stat.v_ge_n   = r_v >= r_n;
    assign o_stat.v_is_s   = r_v == NW'(r_s);
    assign o_stat.push_sat = w_push_sat;
    assign o_stat.push_drn = w_push_drn;
    assign o_stat.cnt_zero = r_cnt == '0;
    assign o_stat.u_is_st  = (r_u == r_s) || (r_u == r_t);
    assign o_stat.exu_zero = r_exu == '0;
    assign o_stat.ptr_ge_n = r_ptr >= r_n;
    assign o_stat.ptr_is_u = r_ptr == NW'(r_u);
    assign o_stat.out_free = w_out_free;

    assign o_out_valid = r_ovalid;
    assign o_out_flow  = r_oflow;
    assign o_out_stat  = r_ostat;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= 32'(MAX_VERTICES))
        else $error("active queue count beyond its depth");
    a_push_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_push |-> (w_d != '0))
        else $error("push of zero flow");
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drain_end |-> (r_exu == '0))
        else $error("vertex retired with excess left");

endmodule

### rtl/push_relabel_max_flow_unit.sv
// Top level of the push-relabel maximum flow unit.
// Joins the controller prmf_ctrl and the datapath prmf_dp; uses prmf_pkg.
//
// Channel   Direction  Signals                               Contents
// s_axis    in         tvalid tready tdata[39:0] tuser[0]    capacity write or run request
// m_axis    out        tvalid tready tdata[23:0] tuser[0]    max flow and run status
// cfg       in         i_cfg_we i_cfg_wdata[6:0]             vertex count
//
// After reset all 2**(2*clog2(MAX_VERTICES)) capacity entries (4096 by default)
// are cleared with s_axis_tready low; configuration writes are still taken.
// A capacity write is stored on acceptance; an invalid run answers the cycle after.
// A valid run clears the flow store (4096 entries by default), then works through
// saturation, pointer steps and pushes, relabel scans and the sink sum.
// A result waiting in the output register holds s_axis_tready low until it is taken.
module push_relabel_max_flow_unit #(
    parameter int MAX_VERTICES = prmf_pkg::MAX_VERTICES_DEF,
    parameter int CAP_WIDTH    = prmf_pkg::CAP_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [prmf_pkg::VC_W-1:0]        i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // from_vertex[5:0], to_vertex[11:6], edge_capacity[27:12],
    // source_vertex[33:28], sink_vertex[39:34]
    input  logic [prmf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // action[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // max_flow[21:0], zero fill[23:22]
    output logic [prmf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // run_status[0]
    output logic                             m_axis_tuser
);
    import prmf_pkg::*;

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [OUT_W-1:0]  w_flow;

    prmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    prmf_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .CAP_WIDTH    (CAP_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_flow  (w_flow),
        .o_out_stat  (m_axis_tuser)
    );

    assign m_axis_tdata = {(OUT_DATA_W - OUT_W)'(0), w_flow};

endmodule

### tb/tb_top.sv
// Self-checking testbench for push_relabel_max_flow_unit: capacity writes and max-flow runs
// are driven over the stream ports, and every result is compared with a built-in predictor.
// Depends on prmf_pkg and the unit's RTL only.
module tb_top;
    import prmf_pkg::*;

    typedef struct {
        logic       action;
        logic [5:0] from_v;
        logic [5:0] to_v;
        logic [15:0] cap;
        logic [5:0] src;
        logic [5:0] snk;
    } t_flow_request;

    class t_flow_scoreboard;
        int unsigned cap_mat[4096];
        longint      flow_mat[4096];
        longint      excess[64];
        int unsigned height[64];
        int unsigned nptr[64];
        int unsigned active[64];
        int unsigned q_head;
        int unsigned q_count;
        int unsigned n_run;
        int unsigned vcount = 64;
        logic [OUT_W-1:0] exp_flow[$];
        logic             exp_status[$];
        int mismatches;
        int writes;
        int valid_runs;
        int invalid_runs;
        int checked;

        function int pending();
            return exp_flow.size();
        endfunction

        function void set_count(logic [VC_W-1:0] v);
            vcount = 32'(v);
        endfunction

        function void add_expected(logic [OUT_W-1:0] f, logic st);
            exp_flow.insert(exp_flow.size(), f);
            exp_status.insert(exp_status.size(), st);
        endfunction

        function longint resid(int unsigned u, int unsigned v);
            return longint'(cap_mat[u*64+v]) - flow_mat[u*64+v];
        endfunction

        function void enqueue(int unsigned v);
            if (q_count < 64) begin
                active[(q_head + q_count) % 64] = v;
                q_count++;
            end
        endfunction

        function void push_flow(int unsigned u, int unsigned v);
            longint r;
            longint d;
            r = resid(u, v);
            d = (excess[u] < r) ? excess[u] : r;
            if (d <= 0) return;
            flow_mat[u*64+v] += d;
            flow_mat[v*64+u] -= d;
            excess[u] -= d;
            excess[v] += d;
            if (excess[v] == d) enqueue(v);
        endfunction

        function void relabel(int unsigned u);
            bit found;
            int unsigned lowest;
            found = 0;
            lowest = 0;
            for (int unsigned i = 0; i < n_run; i++) begin
                if (i != u && resid(u, i) > 0) begin
                    if (!found || height[i] < lowest) lowest = height[i];
                    found = 1;
                end
            end
            if (found) height[u] = lowest + 1;
        endfunction

        function void discharge(int unsigned u);
            int unsigned v;
            while (excess[u] > 0) begin
                if (nptr[u] < n_run) begin
                    v = nptr[u];
                    if (v != u && resid(u, v) > 0 && height[u] > height[v]) begin
                        push_flow(u, v);
                    end else begin
                        nptr[u]++;
                    end
                end else begin
                    relabel(u);
                    nptr[u] = 0;
                end
            end
        endfunction

        function void note_request(t_flow_request r);
            int unsigned s;
            int unsigned t;
            int unsigned n;
            int unsigned u;
            longint total;
            if (r.action == ACT_WRITE) begin
                cap_mat[32'(r.from_v)*64 + 32'(r.to_v)] = 32'(r.cap);
                writes++;
                return;
            end
            s = 32'(r.src);
            t = 32'(r.snk);
            n = (vcount > 64) ? 64 : vcount;
            if (s == t || s >= n || t >= n) begin
                add_expected('0, ST_INVALID);
                invalid_runs++;
                return;
            end
            n_run = n;
            foreach (flow_mat[i]) flow_mat[i] = 0;
            for (int i = 0; i < 64; i++) begin
                excess[i] = 0;
                height[i] = 0;
                nptr[i] = 0;
            end
            q_head = 0;
            q_count = 0;
            height[s] = n;
            excess[s] = longint'(INT_MAX);
            for (int unsigned i = 0; i < n; i++)
                if (i != s) push_flow(s, i);
            while (q_count > 0) begin
                u = active[q_head % 64];
                q_head = (q_head + 1) % 64;
                q_count--;
                if (u != s && u != t) discharge(u);
            end
            total = 0;
            for (int unsigned i = 0; i < n; i++) total += flow_mat[i*64 + t];
            if (total < 0) total = 0;
            if (total > longint'(FLOW_OUT_MAX)) total = longint'(FLOW_OUT_MAX);
            add_expected(total[OUT_W-1:0], ST_VALID);
            valid_runs++;
        endfunction

        function void check_result(logic [OUT_W-1:0] flow, logic status);
            logic [OUT_W-1:0] ef;
            logic             es;
            checked++;
            if (exp_flow.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual flow %0d status %0d",
                         $time, flow, status);
                mismatches++;
                return;
            end
            ef = exp_flow.pop_front();
            es = exp_status.pop_front();
            if (flow !== ef) begin
                $display("%0t: max_flow mismatch, expected %0d actual %0d", $time, ef, flow);
                mismatches++;
            end
            if (status !== es) begin
                $display("%0t: run_status mismatch, expected %0d actual %0d", $time, es, status);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [VC_W-1:0]       i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    t_flow_scoreboard sb = new();
    int send_idle;
    int recv_idle;

    push_relabel_max_flow_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 30_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[OUT_W-1:0], m_axis_tuser);
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_request(t_flow_request r);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.action;
        s_axis_tdata  <= {r.snk, r.src, r.cap, r.to_v, r.from_v};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(logic [VC_W-1:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_count(v);
    endtask

    task automatic write_cap(int f, int t, int c);
        t_flow_request r;
        r = '{ACT_WRITE, f[5:0], t[5:0], c[15:0], 6'($urandom), 6'($urandom)};
        send_request(r);
    endtask

    task automatic run_flow(int s, int t);
        t_flow_request r;
        r = '{ACT_RUN, 6'($urandom), 6'($urandom), 16'($urandom), s[5:0], t[5:0]};
        send_request(r);
    endtask

    // Writes mostly land on the low vertices so that runs see dense small graphs.
    task automatic random_items(int count, int focus, int n, int run_pct);
        t_flow_request r;
        int pick;
        for (int k = 0; k < count; k++) begin
            r.action = ($urandom_range(99) < run_pct) ? ACT_RUN : ACT_WRITE;
            r.from_v = 6'(($urandom_range(9) < 8) ? $urandom_range(focus - 1)
                                                  : $urandom_range(63));
            r.to_v   = 6'(($urandom_range(9) < 8) ? $urandom_range(focus - 1)
                                                  : $urandom_range(63));
            pick = $urandom_range(9);
            r.cap    = (pick < 2) ? 16'd0 : (pick == 2) ? 16'hFFFF : 16'($urandom);
            if ($urandom_range(99) < 85) begin
                r.src = 6'($urandom_range(n - 1));
                r.snk = 6'($urandom_range(n - 1));
            end else begin
                r.src = 6'($urandom_range(63));
                r.snk = 6'($urandom_range(63));
            end
            send_request(r);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_WRITE;
        send_idle = 0;
        recv_idle = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Runs at the reset vertex count over an empty graph.
        run_flow(0, 63);
        run_flow(63, 0);
        set_vertex_count(7'd4);
        write_cap(0, 0, 65535);
        write_cap(63, 63, 65535);
        write_cap(0, 1, 65535);
        write_cap(1, 3, 1);
        write_cap(0, 2, 40000);
        write_cap(2, 3, 65535);
        write_cap(1, 2, 7);
        write_cap(3, 0, 65535);
        run_flow(0, 3);
        run_flow(0, 0);
        run_flow(0, 63);
        run_flow(63, 0);
        run_flow(3, 0);
        write_cap(0, 1, 0);
        run_flow(0, 3);
        set_vertex_count(7'd0);
        run_flow(0, 1);
        set_vertex_count(7'd1);
        run_flow(0, 1);
        set_vertex_count(7'd127);
        write_cap(62, 63, 65535);
        write_cap(0, 62, 65535);
        run_flow(0, 63);
        run_flow(63, 62);

        set_vertex_count(7'd6);
        send_idle = 31;
        recv_idle = 55;
        random_items(350, 6, 6, 12);

        set_vertex_count(7'd64);
        send_idle = 55;
        recv_idle = 31;
        random_items(330, 10, 10, 5);

        set_vertex_count(7'd2);
        send_idle = 0;
        recv_idle = 0;
        random_items(120, 2, 2, 15);
        set_vertex_count(7'($urandom_range(3, 12)));
        random_items(210, 8, sb.vcount, 12);

        wait_drained();
        $display("Covered %0d capacity writes, %0d valid and %0d invalid runs;",
                 sb.writes, sb.valid_runs, sb.invalid_runs);
        $display("%0d results checked, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/prmf_pkg.sv
rtl/prmf_ram.sv
rtl/prmf_ctrl.sv
rtl/prmf_dp.sv
rtl/push_relabel_max_flow_unit.sv
tb/tb_top.sv
